### design/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the periodic task scheduler
// Task memory entry layout, action and register codes, slot evaluation word
// and the result word.
// ----------------------------------------------------------------------------
package pts_pkg;

   // Per-task state held in the task memory
   typedef struct packed {
      logic [15:0] ticks_left;
      logic [31:0] release_time;
      logic [31:0] due_time;
      logic [31:0] instance_count;
      logic [31:0] miss_count;
   } task_entry_type;

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_RESTART = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_POLICY   = 3'd0;
   localparam logic [2:0] CSR_COUNT    = 3'd1;
   localparam logic [2:0] CSR_TASKS_01 = 3'd2;
   localparam logic [2:0] CSR_TASKS_67 = 3'd5;

   localparam int TASK_WORDS = 4;

   localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Outcome of the release step for one slot
   typedef struct packed {
      task_entry_type entry;
      logic           released;
      logic           eligible;
      logic [31:0]    key;
      logic           miss_idle;
      logic           miss_run;
   } slot_eval_type;

   // One result word
   typedef struct packed {
      logic [31:0] time_now;
      logic        idle;
      logic [2:0]  running_task;
      logic [15:0] remaining_after;
      logic [31:0] running_deadline;
      logic [7:0]  release_mask;
      logic [7:0]  miss_mask;
      logic [31:0] instance_total;
      logic [31:0] miss_total;
   } result_type;

endpackage

### design/periodic_task_scheduler_rm_edf_unit.sv
// Tick word: two passes over the N task slots in use, one slot per cycle
// through the task memory's read port. Counter read: one memory read.
// Restart and no-op words: no pass over the task memory.
// One word is in work at a time; a new word is taken while a result waits.
// Reset is synchronous: control registers clear and the task memory's valid bits
// clear at once, so every task entry reads as zero; no clearing pass.
// ----------------------------------------------------------------------------
// periodic_task_scheduler_rm_edf_unit: RM / EDF periodic task scheduler
// Per-task state in one memory; a release pass picks the task to run, a
// commit pass charges its tick and counts deadline misses.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_rm_edf_unit import pts_pkg::*; #(
   parameter int TASK_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_task_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_time_now,
   output logic        rsp_idle,
   output logic [2:0]  rsp_running_task,
   output logic [15:0] rsp_remaining_after,
   output logic [31:0] rsp_running_deadline,
   output logic [7:0]  rsp_release_mask,
   output logic [7:0]  rsp_miss_mask,
   output logic [31:0] rsp_instance_total,
   output logic [31:0] rsp_miss_total,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_READ_DATA = 5'b00010,
      S_SCAN      = 5'b00100,
      S_COMMIT    = 5'b01000,
      S_FINISH    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic                         cfg_policy_ff, cfg_policy_in;
   logic [3:0]                   cfg_count_ff, cfg_count_in;
   logic [TASK_WORDS-1:0][63:0]  cfg_task_ff, cfg_task_in;
   logic [31:0]                  tick_ff, tick_in;
   logic                         qidx_ok_ff, qidx_ok_in;
   logic [CNT_W-1:0]             issue_cnt_ff, issue_cnt_in;
   logic                         proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]             proc_idx_ff, proc_idx_in;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic [31:0]                  best_key_ff, best_key_in;
   logic [15:0]                  best_tl_ff, best_tl_in;
   logic [31:0]                  best_due_ff, best_due_in;
   logic [7:0]                   rel_mask_ff, rel_mask_in;
   logic [7:0]                   miss_mask_ff, miss_mask_in;
   logic [7:0]                   miss_idle_ff, miss_idle_in;
   logic [7:0]                   miss_run_ff, miss_run_in;
   result_type                   res_ff, res_in;
   result_type                   rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         ram_clear;
   logic                         ram_wr_en;
   logic [IDX_W-1:0]             ram_wr_addr;
   task_entry_type               ram_wr_data;
   logic                         ram_rd_en;
   logic [IDX_W-1:0]             ram_rd_addr;
   task_entry_type               ram_rd_data;

   logic [CNT_W-1:0]             n_slots;
   logic [2:0]                   proc_idx3;
   logic [63:0]                  proc_word;
   logic [31:0]                  proc_half;
   logic [7:0]                   proc_bit;
   slot_eval_type                eval;
   task_entry_type               commit_entry;
   logic                         is_best;
   logic                         missed;

   pts_task_ram #(
      .DEPTH  (TASK_SLOTS),
      .ADDR_W (IDX_W)
   ) u_task_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (ram_clear),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign n_slots   = (cfg_count_ff > 4'(TASK_SLOTS)) ? CNT_W'(TASK_SLOTS)
                                                       : CNT_W'(cfg_count_ff);
   assign proc_idx3 = 3'(proc_idx_ff);
   assign proc_word = cfg_task_ff[proc_idx3[2:1]];
   assign proc_half = proc_idx3[0] ? proc_word[63:32] : proc_word[31:0];
   assign proc_bit  = 8'b0000_0001 << proc_idx3;

   pts_slot_eval u_slot_eval (
      .entry    (ram_rd_data),
      .period   (proc_half[15:0]),
      .wcet     (proc_half[31:16]),
      .tick     (tick_ff),
      .edf_mode (cfg_policy_ff),
      .result   (eval)
   );

   always_comb begin
      state_in      = state_ff;
      cfg_policy_in = cfg_policy_ff;
      cfg_count_in  = cfg_count_ff;
      cfg_task_in   = cfg_task_ff;
      tick_in       = tick_ff;
      qidx_ok_in    = qidx_ok_ff;
      issue_cnt_in  = issue_cnt_ff;
      proc_valid_in = 1'b0;
      proc_idx_in   = proc_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      best_tl_in    = best_tl_ff;
      best_due_in   = best_due_ff;
      rel_mask_in   = rel_mask_ff;
      miss_mask_in  = miss_mask_ff;
      miss_idle_in  = miss_idle_ff;
      miss_run_in   = miss_run_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      req_stall    = 1'b1;
      ram_clear    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = proc_idx_ff;
      ram_wr_data  = eval.entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_cnt_ff[IDX_W-1:0];
      commit_entry = ram_rd_data;
      is_best      = found_ff && proc_idx_ff == best_idx_ff;
      missed       = is_best ? miss_run_ff[proc_idx3] : miss_idle_ff[proc_idx3];

      if (csr_write) begin
         case (csr_index)
            CSR_POLICY: begin
               cfg_policy_in = csr_data[0];
            end
            CSR_COUNT: begin
               cfg_count_in = csr_data[3:0];
            end
            default: begin
               if (csr_index inside {[CSR_TASKS_01:CSR_TASKS_67]}) begin
                  cfg_task_in[2'(csr_index - CSR_TASKS_01)] = csr_data;
               end
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               res_in          = '0;
               res_in.idle     = 1'b1;
               res_in.time_now = tick_ff;
               case (action_type'(req_action))
                  ACT_TICK: begin
                     issue_cnt_in = '0;
                     found_in     = 1'b0;
                     rel_mask_in  = '0;
                     miss_mask_in = '0;
                     miss_idle_in = '0;
                     miss_run_in  = '0;
                     state_in     = S_SCAN;
                  end
                  ACT_RESTART: begin
                     ram_clear       = 1'b1;
                     tick_in         = '0;
                     res_in.time_now = '0;
                     state_in        = S_FINISH;
                  end
                  ACT_READ: begin
                     qidx_ok_in  = 4'(req_task_index) < 4'(TASK_SLOTS);
                     ram_rd_en   = qidx_ok_in;
                     ram_rd_addr = req_task_index[IDX_W-1:0];
                     state_in    = S_READ_DATA;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_READ_DATA: begin
            if (qidx_ok_ff) begin
               res_in.instance_total = ram_rd_data.instance_count;
               res_in.miss_total     = ram_rd_data.miss_count;
            end
            state_in = S_FINISH;
         end

         S_SCAN: begin
            ram_rd_en = issue_cnt_ff < n_slots;
            if (ram_rd_en) begin
               issue_cnt_in  = issue_cnt_ff + CNT_W'(1);
               proc_valid_in = 1'b1;
               proc_idx_in   = ram_rd_addr;
            end else begin
               issue_cnt_in = '0;
               state_in     = S_COMMIT;
            end
            if (proc_valid_ff) begin
               ram_wr_en = 1'b1;
               if (eval.released) begin
                  rel_mask_in = rel_mask_ff | proc_bit;
               end
               if (eval.miss_idle) begin
                  miss_idle_in = miss_idle_ff | proc_bit;
               end
               if (eval.miss_run) begin
                  miss_run_in = miss_run_ff | proc_bit;
               end
               // strict compare: ties stay with the lower index
               if (eval.eligible && (!found_ff || eval.key < best_key_ff)) begin
                  found_in    = 1'b1;
                  best_idx_in = proc_idx_ff;
                  best_key_in = eval.key;
                  best_tl_in  = eval.entry.ticks_left - 16'd1;
                  best_due_in = eval.entry.due_time;
               end
            end
         end

         S_COMMIT: begin
            ram_rd_en = issue_cnt_ff < n_slots;
            if (ram_rd_en) begin
               issue_cnt_in  = issue_cnt_ff + CNT_W'(1);
               proc_valid_in = 1'b1;
               proc_idx_in   = ram_rd_addr;
            end
            if (proc_valid_ff) begin
               if (is_best) begin
                  commit_entry.ticks_left = ram_rd_data.ticks_left - 16'd1;
               end
               if (missed) begin
                  miss_mask_in = miss_mask_ff | proc_bit;
                  if (ram_rd_data.miss_count != COUNT_MAX) begin
                     commit_entry.miss_count = ram_rd_data.miss_count + 32'd1;
                  end
               end
               ram_wr_en   = 1'b1;
               ram_wr_data = commit_entry;
            end
            if (!ram_rd_en) begin
               res_in.time_now     = tick_ff;
               res_in.idle         = !found_ff;
               res_in.running_task = found_ff ? 3'(best_idx_ff) : 3'd0;
               res_in.remaining_after  = found_ff ? best_tl_ff : 16'd0;
               res_in.running_deadline = found_ff ? best_due_ff : 32'd0;
               res_in.release_mask = rel_mask_ff;
               res_in.miss_mask    = miss_mask_in;
               tick_in             = tick_ff + 32'd1;
               state_in            = S_FINISH;
            end
         end

         S_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cfg_policy_ff <= 1'b0;
         cfg_count_ff  <= 4'd1;
         cfg_task_ff   <= '0;
         tick_ff       <= '0;
         issue_cnt_ff  <= '0;
         proc_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_policy_ff <= cfg_policy_in;
         cfg_count_ff  <= cfg_count_in;
         cfg_task_ff   <= cfg_task_in;
         tick_ff       <= tick_in;
         issue_cnt_ff  <= issue_cnt_in;
         proc_valid_ff <= proc_valid_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qidx_ok_ff   <= qidx_ok_in;
      proc_idx_ff  <= proc_idx_in;
      best_idx_ff  <= best_idx_in;
      best_key_ff  <= best_key_in;
      best_tl_ff   <= best_tl_in;
      best_due_ff  <= best_due_in;
      rel_mask_ff  <= rel_mask_in;
      miss_mask_ff <= miss_mask_in;
      miss_idle_ff <= miss_idle_in;
      miss_run_ff  <= miss_run_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_time_now         = rsp_ff.time_now;
   assign rsp_idle             = rsp_ff.idle;
   assign rsp_running_task     = rsp_ff.running_task;
   assign rsp_remaining_after  = rsp_ff.remaining_after;
   assign rsp_running_deadline = rsp_ff.running_deadline;
   assign rsp_release_mask     = rsp_ff.release_mask;
   assign rsp_miss_mask        = rsp_ff.miss_mask;
   assign rsp_instance_total   = rsp_ff.instance_total;
   assign rsp_miss_total       = rsp_ff.miss_total;

`ifndef SYNTH
   // A pass never reads the entry it is writing back in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("task memory read and write hit the same entry");

   // A finished result waits while the output register is still stalled
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && rsp_stall) |=>
      (state_ff == S_FINISH))
      else $error("result moved into a stalled output register");

   // The end of the commit pass advances the tick by exactly one
   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && !ram_rd_en) |=>
      (tick_ff == $past(tick_ff) + 32'd1))
      else $error("tick counter did not advance after a tick word");
`endif

endmodule

### design/pts_task_ram.sv
// ----------------------------------------------------------------------------
// pts_task_ram: per-task state memory
// One write and one read port, registered read data, a valid bit per entry
// so that unwritten entries read as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module pts_task_ram import pts_pkg::*; #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  task_entry_type      wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output task_entry_type      rd_data
);

   task_entry_type mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   task_entry_type   rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/pts_slot_eval.sv
// ----------------------------------------------------------------------------
// pts_slot_eval: release and priority evaluation of one task slot
// Applies a due release, forms the priority key for the active policy and
// flags a deadline miss for both outcomes of the run decision.
// ----------------------------------------------------------------------------
module pts_slot_eval import pts_pkg::*; (
   input  task_entry_type entry,
   input  logic [15:0]    period,
   input  logic [15:0]    wcet,
   input  logic [31:0]    tick,
   input  logic           edf_mode,
   output slot_eval_type  result
);

   logic        enabled;
   logic        released;
   logic [31:0] rel_next;
   logic        due_now;
   task_entry_type next_entry;

   always_comb begin
      enabled      = period != 16'd0;
      released     = enabled && entry.release_time == tick;
      rel_next     = tick + 32'(period);

      next_entry = entry;
      if (released) begin
         next_entry.ticks_left   = wcet;
         next_entry.due_time     = rel_next;
         next_entry.release_time = rel_next;
         if (entry.instance_count != COUNT_MAX) begin
            next_entry.instance_count = entry.instance_count + 32'd1;
         end
      end

      due_now = enabled && next_entry.due_time == tick + 32'd1;

      result.entry    = next_entry;
      result.released = released;
      result.eligible = enabled && next_entry.ticks_left != 16'd0;
      // EDF: signed distance to the deadline, biased so unsigned order works
      result.key      = edf_mode ? ((next_entry.due_time - tick) ^ SIGN_FLIP)
                                 : {16'h0000, period};
      result.miss_idle = due_now && next_entry.ticks_left != 16'd0;
      result.miss_run  = due_now && next_entry.ticks_left > 16'd1;
   end

endmodule

### tb/sv/sched_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// sched_scoreboard_pkg: expected-result store for the RM / EDF scheduler
// Keeps its own copy of the task registers and the per-task timeline, works
// out the result word of every accepted request and checks returned words in
// order.
// ----------------------------------------------------------------------------
package sched_scoreboard_pkg;
   timeunit 1ns;
   timeprecision 1ps;
   import pts_pkg::*;

   localparam int SLOT_COUNT = 8;

   class sched_scoreboard;
      bit          edf_mode;
      bit [3:0]    tasks_in_use;
      bit [63:0]   task_words [TASK_WORDS];
      bit [31:0]   tick_now;
      bit [15:0]   work_left [SLOT_COUNT];
      bit [31:0]   release_at [SLOT_COUNT];
      bit [31:0]   deadline [SLOT_COUNT];
      bit [31:0]   instances [SLOT_COUNT];
      bit [31:0]   misses [SLOT_COUNT];
      result_type  expected_q [$];
      int          errors;

      function new();
         edf_mode = 1'b0;
         tasks_in_use = 4'd1;
         foreach (task_words[i]) task_words[i] = '0;
         errors = 0;
         restart_timeline();
      endfunction

      function void restart_timeline();
         tick_now = '0;
         for (int k = 0; k < SLOT_COUNT; k++) begin
            work_left[k] = '0;
            release_at[k] = '0;
            deadline[k] = '0;
            instances[k] = '0;
            misses[k] = '0;
         end
      endfunction

      function void set_register(bit [2:0] index, bit [63:0] data);
         case (index)
            CSR_POLICY: edf_mode = data[0];
            CSR_COUNT: tasks_in_use = data[3:0];
            default: begin
               if (index >= CSR_TASKS_01 && index <= CSR_TASKS_67)
                  task_words[index - CSR_TASKS_01] = data;
            end
         endcase
      endfunction

      function bit [31:0] task_half(int k);
         bit [63:0] w;
         w = task_words[k / 2];
         return (k % 2 == 1) ? w[63:32] : w[31:0];
      endfunction

      function bit [31:0] bump(bit [31:0] v);
         return (v == COUNT_MAX) ? v : v + 32'd1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Work out the result word of one accepted request
      function void note_word(action_type act, bit [2:0] index);
         result_type want;
         int         n;
         int         best;
         bit [31:0]  key;
         bit [31:0]  best_key;
         bit [31:0]  t;
         bit [31:0]  half;
         bit [15:0]  period;
         want = '0;
         want.idle = 1'b1;
         n = (tasks_in_use > SLOT_COUNT) ? SLOT_COUNT : int'(tasks_in_use);
         best = -1;
         best_key = '0;
         case (act)
            ACT_RESTART: restart_timeline();
            ACT_READ, ACT_NOP: begin
               want.time_now = tick_now;
               if (act == ACT_READ) begin
                  want.instance_total = instances[index];
                  want.miss_total = misses[index];
               end
            end
            default: begin
               t = tick_now;
               // release every enabled task that is due now
               for (int k = 0; k < n; k++) begin
                  half = task_half(k);
                  period = half[15:0];
                  if (period != 0 && release_at[k] == t) begin
                     work_left[k] = half[31:16];
                     deadline[k] = t + period;
                     release_at[k] = t + period;
                     instances[k] = bump(instances[k]);
                     want.release_mask[k] = 1'b1;
                  end
               end
               // pick the winner; in EDF mode a passed deadline counts as most urgent
               for (int k = 0; k < n; k++) begin
                  half = task_half(k);
                  period = half[15:0];
                  if (period != 0 && work_left[k] != 0) begin
                     key = edf_mode ? ((deadline[k] - t) ^ SIGN_FLIP) : {16'd0, period};
                     if (best < 0 || key < best_key) begin
                        best = k;
                        best_key = key;
                     end
                  end
               end
               if (best >= 0) begin
                  work_left[best] = work_left[best] - 16'd1;
                  want.idle = 1'b0;
                  want.running_task = 3'(best);
                  want.remaining_after = work_left[best];
                  want.running_deadline = deadline[best];
               end
               for (int k = 0; k < n; k++) begin
                  half = task_half(k);
                  period = half[15:0];
                  if (period != 0 && work_left[k] != 0 && deadline[k] == t + 32'd1) begin
                     misses[k] = bump(misses[k]);
                     want.miss_mask[k] = 1'b1;
                  end
               end
               want.time_now = t;
               tick_now = t + 32'd1;
            end
         endcase
         expected_q.push_back(want);
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result word with none expected, time_now actual %0h",
                     $time, got.time_now);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare("time_now", want.time_now, got.time_now);
         compare("idle", 32'(want.idle), 32'(got.idle));
         compare("running_task", 32'(want.running_task), 32'(got.running_task));
         compare("remaining_after", 32'(want.remaining_after), 32'(got.remaining_after));
         compare("running_deadline", want.running_deadline, got.running_deadline);
         compare("release_mask", 32'(want.release_mask), 32'(got.release_mask));
         compare("miss_mask", 32'(want.miss_mask), 32'(got.miss_mask));
         compare("instance_total", want.instance_total, got.instance_total);
         compare("miss_total", want.miss_total, got.miss_total);
      endfunction
   endclass

endpackage

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: RM / EDF periodic task scheduler
// A directed run over the task set extremes, then phases of random requests
// under changing task sets, with random gaps on both channels and one long
// result hold-off. Every result word is checked against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pts_pkg::*;
   import sched_scoreboard_pkg::*;

   localparam int WORD_TARGET = 850;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_TICK;
   logic [2:0]  req_task_index = 3'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_time_now;
   logic        rsp_idle;
   logic [2:0]  rsp_running_task;
   logic [15:0] rsp_remaining_after;
   logic [31:0] rsp_running_deadline;
   logic [7:0]  rsp_release_mask;
   logic [7:0]  rsp_miss_mask;
   logic [31:0] rsp_instance_total;
   logic [31:0] rsp_miss_total;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = CSR_POLICY;
   logic [63:0] csr_data = '0;

   result_type      rsp_word;
   sched_scoreboard sched;
   int              req_idle_pct = 0;
   int              rsp_idle_pct = 0;
   int              words_sent = 0;
   int              hold_left = 0;
   bit              hold_start = 1'b0;

   assign rsp_word = {rsp_time_now, rsp_idle, rsp_running_task, rsp_remaining_after,
                      rsp_running_deadline, rsp_release_mask, rsp_miss_mask,
                      rsp_instance_total, rsp_miss_total};

   periodic_task_scheduler_rm_edf_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_task_index       (req_task_index),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_time_now         (rsp_time_now),
      .rsp_idle             (rsp_idle),
      .rsp_running_task     (rsp_running_task),
      .rsp_remaining_after  (rsp_remaining_after),
      .rsp_running_deadline (rsp_running_deadline),
      .rsp_release_mask     (rsp_release_mask),
      .rsp_miss_mask        (rsp_miss_mask),
      .rsp_instance_total   (rsp_instance_total),
      .rsp_miss_total       (rsp_miss_total),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #2 clock = ~clock;

   // Result side: check accepted words, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sched.check_result(rsp_word);
      if (hold_start) begin
         hold_left = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Offer one word and hold it until the block takes it
   task automatic send_word(action_type act, logic [2:0] index);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_task_index <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sched.note_word(act, index);
      words_sent++;
   endtask

   // Drop valid and let every outstanding result drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sched.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Caller lowers csr_write after the last write of a batch
   task automatic write_reg(logic [2:0] index, logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      sched.set_register(index, data);
   endtask

   function automatic logic [31:0] random_task();
      logic [15:0] period;
      logic [15:0] wcet;
      if ($urandom_range(19) == 0)
         return $urandom;
      period = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
      wcet = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 30))
                                      : 16'($urandom_range(0, 4));
      return {wcet, period};
   endfunction

   task automatic configure_random();
      logic [63:0] data;
      data = {$urandom, $urandom};
      write_reg(CSR_POLICY, data);
      data = {$urandom, $urandom};
      if ($urandom_range(4) != 0)
         data[3:0] = ($urandom_range(1) == 0) ? 4'd8 : 4'($urandom_range(1, 7));
      write_reg(CSR_COUNT, data);
      for (int k = 0; k < TASK_WORDS; k++) begin
         if ($urandom_range(3) != 0)
            write_reg(CSR_TASKS_01 + 3'(k), {random_task(), random_task()});
      end
      csr_write <= 1'b0;
   endtask

   initial begin : stimulus
      int          phase;
      int          run_length;
      int          pick;
      action_type  act;
      sched = new();
      req_idle_pct = 32;
      rsp_idle_pct = 45;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset task set: one task, period zero
      send_word(ACT_TICK, 3'd0);
      send_word(ACT_TICK, 3'd0);
      wait_idle();

      // directed set: disabled task, zero wcet, overrun, largest period and wcet
      write_reg(CSR_POLICY, 64'd0);
      write_reg(CSR_COUNT, 64'd8);
      write_reg(CSR_TASKS_01, {16'd2, 16'd6, 16'd1, 16'd4});
      write_reg(CSR_TASKS_01 + 3'd1, {16'd0, 16'd5, 16'd3, 16'd0});
      write_reg(CSR_TASKS_01 + 3'd2, {16'hFFFF, 16'hFFFF, 16'd5, 16'd3});
      write_reg(CSR_TASKS_67, {16'd1, 16'd2, 16'd2, 16'd8});
      csr_write <= 1'b0;
      repeat (8) send_word(ACT_TICK, 3'd0);
      send_word(ACT_READ, 3'd0);
      send_word(ACT_READ, 3'd7);
      send_word(ACT_NOP, 3'd5);
      send_word(ACT_RESTART, 3'd2);
      repeat (3) send_word(ACT_TICK, 3'd7);
      wait_idle();
      write_reg(CSR_POLICY, 64'd1);
      csr_write <= 1'b0;
      repeat (6) send_word(ACT_TICK, 3'd0);
      send_word(ACT_READ, 3'd4);

      phase = 0;
      while (words_sent < WORD_TARGET) begin
         if (words_sent < WORD_TARGET / 3) begin
            req_idle_pct = 32;
            rsp_idle_pct = 45;
         end else if (words_sent < 2 * WORD_TARGET / 3) begin
            req_idle_pct = 45;
            rsp_idle_pct = 32;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         wait_idle();
         configure_random();
         // fill the block while results are held back
         if (phase == 3)
            hold_start = 1'b1;
         run_length = $urandom_range(30, 90);
         repeat (run_length) begin
            pick = $urandom_range(99);
            if (pick < 82)
               act = ACT_TICK;
            else if (pick < 93)
               act = ACT_READ;
            else if (pick < 96)
               act = ACT_RESTART;
            else
               act = ACT_NOP;
            send_word(act, 3'($urandom_range(7)));
         end
         phase++;
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (sched.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
